/* rtl/mfrx_pkg.sv */
package mfrx_pkg;

  localparam int DEF_PAYLOAD_BYTES = 16;
  localparam int DEF_FRAME_BYTES   = 17;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  typedef enum logic [1:0] {
    ST_WORD     = 2'd0,
    ST_LEN_ERR  = 2'd1,
    ST_SUM_ERR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic    err_vld;
    status_t err_status;
    logic    start;
  } emit_req_t;

  typedef struct packed {
    logic active;
    logic a_free;
  } emit_stat_t;

endpackage

/* rtl/mfrx_store.sv */
module mfrx_store #(
  parameter int NW  = 4,
  parameter int WAW = 2
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [WAW-1:0] wr_addr,
  input  logic [1:0]     wr_lane,
  input  logic [7:0]     wr_data,
  input  logic           rd_en,
  input  logic [WAW-1:0] rd_addr,
  output logic [31:0]    rd_data
);
  import mfrx_pkg::*;

  logic [31:0] mem [NW];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/mfrx_parse.sv */
module mfrx_parse #(
  parameter int PAYLOAD_BYTES = 16,
  parameter int FRAME_BYTES   = 17,
  parameter int WAW           = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_rx_byte,
  output logic                   in_stall,
  input  mfrx_pkg::emit_stat_t   stat,
  input  logic [WAW-1:0]         rd_ptr,
  output mfrx_pkg::emit_req_t    req,
  output logic                   wr_en,
  output logic [WAW-1:0]         wr_addr,
  output logic [1:0]             wr_lane,
  output logic [7:0]             wr_data
);
  import mfrx_pkg::*;

  localparam int CW      = $clog2(FRAME_BYTES + 1);
  localparam int PW      = (PAYLOAD_BYTES < FRAME_BYTES) ? PAYLOAD_BYTES : FRAME_BYTES;
  localparam bit HAS_CHK = (PAYLOAD_BYTES < FRAME_BYTES);

  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    chk_r, chk_nxt;

  logic              is_end, is_start, is_full, is_chk, store_ok, res_ok, ok, fire;
  logic [CW+WAW-1:0] word_wide;

  always_comb begin
    is_end    = (in_rx_byte == END_BYTE);
    is_start  = (in_rx_byte == START_BYTE);
    is_full   = (count_r == CW'(FRAME_BYTES));
    store_ok  = in_frame_r && !is_end && !is_full && (count_r < CW'(PW));
    is_chk    = HAS_CHK && (count_r == CW'(PAYLOAD_BYTES));
    word_wide = {{WAW{1'b0}}, count_r} >> 2;
    wr_addr   = word_wide[WAW-1:0];
    wr_lane   = count_r[1:0];
    wr_data   = in_rx_byte;
    res_ok    = !stat.active && stat.a_free;

    if (!in_frame_r) begin
      ok = 1'b1;
    end else if (is_end || is_full) begin
      ok = res_ok;
    end else if (store_ok) begin
      ok = !(stat.active && (wr_addr >= rd_ptr));
    end else begin
      ok = 1'b1;
    end
    in_stall = !ok;
    fire     = in_valid && ok;
    wr_en    = fire && store_ok;

    in_frame_nxt   = in_frame_r;
    count_nxt      = count_r;
    xor_nxt        = xor_r;
    chk_nxt        = chk_r;
    req.err_vld    = 1'b0;
    req.err_status = ST_LEN_ERR;
    req.start      = 1'b0;

    if (fire) begin
      if (!in_frame_r) begin
        if (is_start) begin
          in_frame_nxt = 1'b1;
          count_nxt    = '0;
          xor_nxt      = '0;
        end
      end else if (is_end) begin
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        if (is_full && HAS_CHK && (xor_r == chk_r)) begin
          req.start = 1'b1;
        end else begin
          req.err_vld    = 1'b1;
          req.err_status = is_full ? ST_SUM_ERR : ST_LEN_ERR;
        end
      end else if (is_full) begin
        in_frame_nxt   = 1'b0;
        count_nxt      = '0;
        req.err_vld    = 1'b1;
        req.err_status = ST_OVERFLOW;
      end else begin
        count_nxt = count_r + CW'(1);
        if (store_ok) begin
          xor_nxt = xor_r ^ in_rx_byte;
        end
        if (is_chk) begin
          chk_nxt = in_rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xor_r <= xor_nxt;
    chk_r <= chk_nxt;
  end

endmodule

/* rtl/mfrx_emit.sv */
module mfrx_emit #(
  parameter int PAYLOAD_BYTES = 16,
  parameter int NW            = 4,
  parameter int WAW           = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mfrx_pkg::emit_req_t    req,
  output mfrx_pkg::emit_stat_t   stat,
  output logic [WAW-1:0]         rd_ptr,
  output logic                   rd_en,
  output logic [WAW-1:0]         rd_addr,
  input  logic [31:0]            rd_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [31:0]            out_payload_word,
  output logic [1:0]             out_word_index,
  output logic                   out_last
);
  import mfrx_pkg::*;

  logic           active_r;
  logic [WAW-1:0] ptr_r;
  logic           a_vld_r;
  status_t        a_status_r;
  logic [WAW-1:0] a_widx_r;
  logic           a_last_r;
  logic           out_valid_r;
  status_t        out_status_r;
  logic [31:0]    out_word_r;
  logic [1:0]     out_idx_r;
  logic           out_last_r;

  logic        a_move, a_free, issue, ptr_last;
  logic [31:0] masked;

  always_comb begin
    a_move   = a_vld_r && (!out_valid_r || !out_stall);
    a_free   = !a_vld_r || a_move;
    issue    = active_r && a_free;
    ptr_last = (ptr_r == WAW'(NW - 1));
    for (int j = 0; j < 4; j++) begin
      masked[j*8 +: 8] = ((int'(a_widx_r) * 4 + j) < PAYLOAD_BYTES) ?
                         rd_data[j*8 +: 8] : 8'h00;
    end
  end

  assign stat.active = active_r;
  assign stat.a_free = a_free;
  assign rd_ptr      = ptr_r;
  assign rd_en       = issue;
  assign rd_addr     = ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ptr_r       <= '0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req.start) begin
        active_r <= 1'b1;
        ptr_r    <= '0;
      end else if (issue) begin
        ptr_r <= ptr_r + WAW'(1);
        if (ptr_last) begin
          active_r <= 1'b0;
        end
      end
      if (issue || req.err_vld) begin
        a_vld_r <= 1'b1;
      end else if (a_move) begin
        a_vld_r <= 1'b0;
      end
      if (a_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_status_r <= ST_WORD;
      a_widx_r   <= ptr_r;
      a_last_r   <= ptr_last;
    end else if (req.err_vld) begin
      a_status_r <= req.err_status;
      a_widx_r   <= '0;
      a_last_r   <= 1'b1;
    end
    if (a_move) begin
      out_status_r <= a_status_r;
      out_word_r   <= (a_status_r == ST_WORD) ? masked : 32'h0;
      out_idx_r    <= 2'(a_widx_r);
      out_last_r   <= a_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_payload_word = out_word_r;
  assign out_word_index   = out_idx_r;
  assign out_last         = out_last_r;

endmodule

/* rtl/marker_frame_receiver_xor.sv */
// Accepts one received byte per cycle while no frame result is pending.
// An error status passes through the A slot register and then the output register.
// A good frame's words go from memory via the A slot register to the output register,
// one word per cycle unless the output stalls; the single read port sets that rate.
// While words are pending, the end byte and writes into unread words are held off.
// Synchronous active-low reset returns to idle with no results pending.
module marker_frame_receiver_xor #(
  parameter int PAYLOAD_BYTES = mfrx_pkg::DEF_PAYLOAD_BYTES,
  parameter int FRAME_BYTES   = mfrx_pkg::DEF_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_payload_word,
  output logic [1:0]  out_word_index,
  output logic        out_last
);
  import mfrx_pkg::*;

  localparam int NW  = (PAYLOAD_BYTES + 3) / 4;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;

  emit_req_t      req;
  emit_stat_t     stat;
  logic [WAW-1:0] rd_ptr;
  logic           wr_en;
  logic [WAW-1:0] wr_addr;
  logic [1:0]     wr_lane;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [WAW-1:0] rd_addr;
  logic [31:0]    rd_data;

  mfrx_parse #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .FRAME_BYTES  (FRAME_BYTES),
    .WAW          (WAW)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_rx_byte(in_rx_byte),
    .in_stall  (in_stall),
    .stat      (stat),
    .rd_ptr    (rd_ptr),
    .req       (req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_lane   (wr_lane),
    .wr_data   (wr_data)
  );

  mfrx_store #(
    .NW (NW),
    .WAW(WAW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_lane(wr_lane),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mfrx_emit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .NW           (NW),
    .WAW          (WAW)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .stat            (stat),
    .rd_ptr          (rd_ptr),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_payload_word(out_payload_word),
    .out_word_index  (out_word_index),
    .out_last        (out_last)
  );

  a_err_word_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_WORD) |-> out_last && (out_payload_word == 32'h0))
    else $error("error status word not marked last or not zero");

  a_no_unread_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && stat.active |-> (wr_addr < rd_ptr))
    else $error("payload word overwritten before it was read");

  a_err_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.err_vld || req.start |-> !stat.active && stat.a_free)
    else $error("frame result raised while words still pending");

  a_last_word_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_WORD) && out_last |-> out_word_index == 2'(NW - 1))
    else $error("last payload word has wrong index");

endmodule
